// File: design/stcd_pkg.sv
// Shared types and constants for the scope trigger/capture core.
// No dependencies; imported by stcd_div and the top level.
`timescale 1ns / 1ps

package stcd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [SAMPLE_W-1:0] TRIG_LEVEL_RST = 12'd500;
    localparam logic [SAMPLE_W-1:0] ROW_STEP_RST   = 12'd64;
    localparam logic [ROW_W-1:0]    BASELINE_RST   = 8'd61;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIG_LEVEL = 2'd0,
        REG_ROW_STEP   = 2'd1,
        REG_BASELINE   = 2'd2
    } t_cfg_reg;

endpackage

// File: design/scope_trigger_capture_display_core.sv
// Top level: capture memory, running min/max, rising-edge trigger and row mapping.
// Depends on stcd_pkg and stcd_div.
`timescale 1ns / 1ps

// Push and clear transactions finish at their accept edge and leave busy low, so
// one can be accepted every cycle. A read raises busy while it passes through the
// capture memory read, the bit-serial divider that maps the sample to a row step
// count, and the divider done handoff. The result registers load at the edge that
// drops busy; a new transaction can be accepted once busy is low. The result is
// shown for one cycle with o_strobe and cannot be held off. Reads of slots not
// written since reset or the last clear return sample zero. No clearing pass is
// needed after reset.
module scope_trigger_capture_display_core
    import stcd_pkg::*;
#(
    parameter int CAPTURE_DEPTH   = 256,
    parameter int DISPLAY_COLUMNS = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_action,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [COLUMN_W-1:0]   i_column,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output logic [ROW_W-1:0]      o_row,
    output logic                  o_trigger_found,
    output logic [COLUMN_W-1:0]   o_trigger_index,
    output logic [SAMPLE_W-1:0]   o_min_code,
    output logic [SAMPLE_W-1:0]   o_max_code,
    output logic                  o_capture_full
);

    localparam int AW  = $clog2(CAPTURE_DEPTH);
    localparam int CW  = $clog2(CAPTURE_DEPTH + 1);
    localparam int TSW = $clog2(DISPLAY_COLUMNS);
    localparam int XW  = ((TSW > COLUMN_W) ? TSW : COLUMN_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(CAPTURE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MEM,
        S_DIV
    } t_state;

    t_state r_state;

    logic [SAMPLE_W-1:0] r_trig_level;
    logic [SAMPLE_W-1:0] r_row_step;
    logic [ROW_W-1:0]    r_baseline;

    logic [CW-1:0]       r_wcount;
    logic [SAMPLE_W-1:0] r_prev;
    logic [TSW-1:0]      r_tstart;
    logic                r_seen;
    logic [SAMPLE_W-1:0] r_min;
    logic [SAMPLE_W-1:0] r_max;
    logic                r_slot_ok;

    logic [SAMPLE_W-1:0] r_mem [CAPTURE_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    logic                w_accept;
    logic                w_push;
    logic                w_full;
    logic [TSW-1:0]      w_start_eff;
    logic [XW-1:0]       w_idx;
    logic [CW-1:0]       w_km1;
    logic                w_cross;
    logic                w_div_start;
    logic                w_div_done;
    logic [SAMPLE_W-1:0] w_quo;
    logic [SAMPLE_W-1:0] w_dividend;
    logic [ROW_W-1:0]    n_row;

    assign w_accept    = start && !busy;
    assign w_full      = (r_wcount >= DEPTH_C);
    assign w_push      = w_accept && (t_action'(i_action) == ACT_PUSH) && !w_full;
    assign w_start_eff = r_seen ? r_tstart : '0;
    assign w_idx       = XW'(i_column) + XW'(w_start_eff);
    assign w_km1       = r_wcount - 1'b1;
    assign w_cross     = !r_seen && (r_wcount != '0)
                         && (32'(w_km1) < 32'(DISPLAY_COLUMNS))
                         && (r_prev <= r_trig_level) && (i_sample > r_trig_level);
    assign w_div_start = (r_state == S_MEM);
    assign w_dividend  = r_slot_ok ? r_rd_data : '0;
    assign n_row       = (w_quo <= SAMPLE_W'(r_baseline))
                         ? (r_baseline - ROW_W'(w_quo)) : '0;

    // capture memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wcount[AW-1:0]] <= i_sample;
        end
        r_rd_data <= r_mem[AW'(w_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_level <= TRIG_LEVEL_RST;
            r_row_step   <= ROW_STEP_RST;
            r_baseline   <= BASELINE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TRIG_LEVEL: r_trig_level <= i_cfg_data[SAMPLE_W-1:0];
                REG_ROW_STEP:   r_row_step   <= i_cfg_data[SAMPLE_W-1:0];
                REG_BASELINE:   r_baseline   <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            busy            <= 1'b0;
            o_strobe        <= 1'b0;
            r_wcount        <= '0;
            r_prev          <= '0;
            r_tstart        <= '0;
            r_seen          <= 1'b0;
            r_min           <= '0;
            r_max           <= '0;
            r_slot_ok       <= 1'b0;
            o_row           <= '0;
            o_trigger_found <= 1'b0;
            o_trigger_index <= '0;
            o_min_code      <= '0;
            o_max_code      <= '0;
            o_capture_full  <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (t_action'(i_action))
                            ACT_PUSH: begin
                                if (!w_full) begin
                                    if (r_wcount == '0) begin
                                        r_min <= i_sample;
                                        r_max <= i_sample;
                                    end else begin
                                        if (i_sample < r_min) r_min <= i_sample;
                                        if (i_sample > r_max) r_max <= i_sample;
                                    end
                                    if (w_cross) begin
                                        r_tstart <= TSW'(w_km1);
                                        r_seen   <= 1'b1;
                                    end
                                    r_prev   <= i_sample;
                                    r_wcount <= r_wcount + 1'b1;
                                end
                            end
                            ACT_CLEAR: begin
                                r_wcount <= '0;
                                r_prev   <= '0;
                                r_tstart <= '0;
                                r_seen   <= 1'b0;
                                r_min    <= '0;
                                r_max    <= '0;
                            end
                            ACT_READ: begin
                                // slot beyond fill level reads as zero
                                r_slot_ok <= (32'(w_idx) < 32'(r_wcount));
                                busy      <= 1'b1;
                                r_state   <= S_MEM;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MEM: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        o_strobe        <= 1'b1;
                        o_row           <= n_row;
                        o_trigger_found <= r_seen;
                        o_trigger_index <= COLUMN_W'(w_start_eff);
                        o_min_code      <= r_min;
                        o_max_code      <= r_max;
                        o_capture_full  <= w_full;
                        busy            <= 1'b0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    stcd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_row_step),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

`ifndef ASSERT_OFF
    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while still busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcount <= DEPTH_C)
        else $error("capture count beyond depth");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_action'(i_action) == ACT_READ)) |=> (busy && !o_strobe))
        else $error("read transaction did not raise busy");

    a_trigger_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_wcount >= CW'(2)))
        else $error("trigger seen with fewer than two samples");
`endif

endmodule

// File: design/stcd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on stcd_pkg for the sample width.
`timescale 1ns / 1ps

module stcd_div
    import stcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SAMPLE_W-1:0] i_dividend,
    input  logic [SAMPLE_W-1:0] i_divisor,
    output logic                o_done,
    output logic [SAMPLE_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SAMPLE_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLE_W - 1);

    logic                r_run;
    logic [CNT_W-1:0]    r_cnt;
    logic [SAMPLE_W-1:0] r_rem;
    logic [SAMPLE_W-1:0] r_quo;
    logic [SAMPLE_W-1:0] r_dsr;

    logic [SAMPLE_W:0]   w_shift;
    logic [SAMPLE_W:0]   w_diff;

    assign w_shift = {r_rem, r_quo[SAMPLE_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};

    // divisor of zero gives all ones, which is the required saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_run) begin
            if (!w_diff[SAMPLE_W]) begin
                r_rem <= w_diff[SAMPLE_W-1:0];
                r_quo <= {r_quo[SAMPLE_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[SAMPLE_W-1:0];
                r_quo <= {r_quo[SAMPLE_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_quo;

endmodule

// File: tb/sv/scope_trigger_capture_display_core_tb.sv
// Self-checking testbench for scope_trigger_capture_display_core: push/read/clear
// transactions against an in-bench capture predictor. Depends on stcd_pkg and the core.
`timescale 1ns / 1ps

module scope_trigger_capture_display_core_tb;
    import stcd_pkg::*;

    localparam int STORE_DEPTH      = 256;
    localparam int VIEW_COLUMNS     = 128;
    localparam int QUOT_SATURATED   = 4095;
    localparam int DRAIN_CYCLES     = 20;
    localparam int TAIL_LIMIT       = 200;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [COLUMN_W-1:0] LAST_COL = COLUMN_W'(VIEW_COLUMNS - 1);

    typedef struct {
        logic [ROW_W-1:0]    row;
        logic                found;
        logic [COLUMN_W-1:0] trig_idx;
        logic [SAMPLE_W-1:0] min_code;
        logic [SAMPLE_W-1:0] max_code;
        logic                full;
    } t_readout;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_action;
    logic [SAMPLE_W-1:0]   i_sample;
    logic [COLUMN_W-1:0]   i_column;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_strobe;
    logic [ROW_W-1:0]      o_row;
    logic                  o_trigger_found;
    logic [COLUMN_W-1:0]   o_trigger_index;
    logic [SAMPLE_W-1:0]   o_min_code;
    logic [SAMPLE_W-1:0]   o_max_code;
    logic                  o_capture_full;

    scope_trigger_capture_display_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_sample        (i_sample),
        .i_column        (i_column),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_row           (o_row),
        .o_trigger_found (o_trigger_found),
        .o_trigger_index (o_trigger_index),
        .o_min_code      (o_min_code),
        .o_max_code      (o_max_code),
        .o_capture_full  (o_capture_full)
    );

    // Predictor state
    logic [SAMPLE_W-1:0] cap_store [STORE_DEPTH];
    logic [8:0]          cap_count;
    logic [SAMPLE_W-1:0] last_code;
    logic [COLUMN_W-1:0] trig_pos;
    logic                trig_hit;
    logic [SAMPLE_W-1:0] low_code;
    logic [SAMPLE_W-1:0] high_code;
    logic [SAMPLE_W-1:0] trig_level;
    logic [SAMPLE_W-1:0] row_step;
    logic [ROW_W-1:0]    base_row;

    t_readout readout_q [$];
    int       err_count;
    int       items_sent;
    int       gap_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    function automatic void capture_restart();
        cap_count = '0;
        last_code = '0;
        trig_pos  = '0;
        trig_hit  = 1'b0;
        low_code  = '0;
        high_code = '0;
    endfunction

    function automatic void capture_push(input logic [SAMPLE_W-1:0] code);
        int k;
        int prev_k;
        k = int'(cap_count);
        if (k >= STORE_DEPTH) return;     // full: sample dropped
        cap_store[k] = code;
        if (k == 0) begin
            low_code  = code;
            high_code = code;
        end else begin
            if (code < low_code) low_code = code;
            if (code > high_code) high_code = code;
            prev_k = k - 1;
            if (!trig_hit && prev_k < VIEW_COLUMNS && last_code <= trig_level &&
                code > trig_level) begin
                trig_pos = prev_k[COLUMN_W-1:0];
                trig_hit = 1'b1;
            end
        end
        last_code = code;
        cap_count = cap_count + 9'd1;
    endfunction

    function automatic t_readout predict_readout(input logic [COLUMN_W-1:0] col);
        t_readout r;
        int origin;
        int slot;
        int code;
        int quot;
        int row_val;
        origin = trig_hit ? int'(trig_pos) : 0;
        slot = int'(col) + origin;
        // unwritten slots and slots past the store read as zero
        code = (slot < STORE_DEPTH && slot < int'(cap_count)) ? int'(cap_store[slot]) : 0;
        quot = (row_step == '0) ? QUOT_SATURATED : code / int'(row_step);
        row_val = (quot <= int'(base_row)) ? int'(base_row) - quot : 0;
        r.row      = row_val[ROW_W-1:0];
        r.found    = trig_hit;
        r.trig_idx = origin[COLUMN_W-1:0];
        r.min_code = low_code;
        r.max_code = high_code;
        r.full     = (int'(cap_count) >= STORE_DEPTH);
        return r;
    endfunction

    function automatic void apply_item(input logic [1:0] act, input logic [SAMPLE_W-1:0] code,
                                       input logic [COLUMN_W-1:0] col);
        case (act)
            ACT_PUSH:  capture_push(code);
            ACT_READ:  readout_q.push_back(predict_readout(col));
            ACT_CLEAR: capture_restart();
            default:   ;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_code();
        int r;
        int v;
        logic [SAMPLE_W-1:0] c;
        r = $urandom_range(99);
        if (r < 45) begin
            // hover around the trigger level so crossings happen often
            v = int'(trig_level) + int'($urandom_range(80)) - 40;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            c = v[SAMPLE_W-1:0];
        end else if (r < 55) begin
            c = $urandom_range(1) ? '1 : '0;
        end else begin
            c = SAMPLE_W'($urandom_range(4095));
        end
        return c;
    endfunction

    function automatic logic [COLUMN_W-1:0] pick_column();
        int span;
        logic [COLUMN_W-1:0] c;
        span = int'(cap_count) - (trig_hit ? int'(trig_pos) : 0);
        if (span > 0 && $urandom_range(99) < 65) begin
            if (span > VIEW_COLUMNS - 1) span = VIEW_COLUMNS - 1;
            c = COLUMN_W'($urandom_range(span));
        end else begin
            c = COLUMN_W'($urandom_range(VIEW_COLUMNS - 1));
        end
        return c;
    endfunction

    always @(posedge i_clk) begin : check_readout
        t_readout want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (readout_q.size() == 0) begin
                report_mismatch("row result with no read pending");
            end else begin
                want = readout_q.pop_front();
                if (o_row !== want.row)
                    report_mismatch($sformatf("row %0d, want %0d", o_row, want.row));
                if (o_trigger_found !== want.found)
                    report_mismatch($sformatf("trigger_found %0b, want %0b",
                                              o_trigger_found, want.found));
                if (o_trigger_index !== want.trig_idx)
                    report_mismatch($sformatf("trigger_index %0d, want %0d",
                                              o_trigger_index, want.trig_idx));
                if (o_min_code !== want.min_code)
                    report_mismatch($sformatf("min_code %0d, want %0d",
                                              o_min_code, want.min_code));
                if (o_max_code !== want.max_code)
                    report_mismatch($sformatf("max_code %0d, want %0d",
                                              o_max_code, want.max_code));
                if (o_capture_full !== want.full)
                    report_mismatch($sformatf("capture_full %0b, want %0b",
                                              o_capture_full, want.full));
            end
        end
    end

    // Called just after a rising edge; returns at the edge that accepted the transaction.
    task automatic send_item(input logic [1:0] act, input logic [SAMPLE_W-1:0] code,
                             input logic [COLUMN_W-1:0] col);
        int gap;
        gap = 0;
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_sample <= code;
        i_column <= col;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_item(act, code, col);
        if (act != ACT_UNUSED) items_sent++;
    endtask

    task automatic do_push(input logic [SAMPLE_W-1:0] code);
        send_item(ACT_PUSH, code, COLUMN_W'($urandom_range(VIEW_COLUMNS - 1)));
    endtask

    task automatic do_read(input logic [COLUMN_W-1:0] col);
        send_item(ACT_READ, SAMPLE_W'($urandom_range(4095)), col);
    endtask

    task automatic do_clear();
        send_item(ACT_CLEAR, SAMPLE_W'($urandom_range(4095)),
                  COLUMN_W'($urandom_range(VIEW_COLUMNS - 1)));
    endtask

    task automatic do_noise();
        send_item(ACT_UNUSED, SAMPLE_W'($urandom_range(4095)),
                  COLUMN_W'($urandom_range(VIEW_COLUMNS - 1)));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (readout_q.size() != 0) @(posedge i_clk);
        // pushes and clears leave nothing to wait on, but give the core time anyway
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes every register (plus the unused index) once the core has gone quiet.
    task automatic load_regs(input logic [SAMPLE_W-1:0] lvl, input logic [SAMPLE_W-1:0] stp,
                             input logic [CFG_DATA_W-1:0] base_raw);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        settle();
        idx[0] = REG_TRIG_LEVEL;
        idx[1] = REG_UNUSED;
        idx[2] = REG_ROW_STEP;
        idx[3] = REG_BASELINE;
        val[0] = lvl;
        val[1] = CFG_DATA_W'($urandom_range(4095));
        val[2] = stp;
        val[3] = base_raw;
        for (int n = 0; n < 4; n++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[n];
            i_cfg_data  <= val[n];
            @(posedge i_clk);
            case (idx[n])
                REG_TRIG_LEVEL: trig_level = val[n];
                REG_ROW_STEP:   row_step   = val[n];
                REG_BASELINE:   base_row   = val[n][ROW_W-1:0];
                default:        ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_regs();
        logic [SAMPLE_W-1:0] stp;
        stp = ($urandom_range(99) < 70) ? SAMPLE_W'($urandom_range(1, 80))
                                        : SAMPLE_W'($urandom_range(4095));
        load_regs(SAMPLE_W'($urandom_range(4095)), stp, CFG_DATA_W'($urandom_range(4095)));
    endtask

    // Capture runs with random content; the first one may continue the current capture.
    task automatic run_captures(input int budget);
        int  goal;
        int  len;
        int  r;
        bit  first;
        goal  = items_sent + budget;
        first = 1'b1;
        while (items_sent < goal) begin
            if (!first || $urandom_range(1)) do_clear();
            first = 1'b0;
            r = $urandom_range(99);
            if (r < 80)      len = $urandom_range(2, 60);
            else if (r < 95) len = $urandom_range(100, 200);
            else             len = $urandom_range(250, 300);
            for (int i = 0; i < len && items_sent < goal; i++) begin
                do_push(pick_code());
                if ($urandom_range(99) < 30) do_read(pick_column());
                if ($urandom_range(99) < 3) do_noise();
            end
            repeat ($urandom_range(1, 3)) do_read(pick_column());
        end
    endtask

    task automatic test_reset_defaults();
        gap_pct = 0;
        do_read('0);
        do_read(LAST_COL);
        do_noise();
        do_read(7'd5);
    endtask

    task automatic test_edge_cases();
        gap_pct = 0;
        do_clear();
        do_push('1);
        do_push('0);
        do_push(12'd500);          // at the level, then just above it
        do_push(12'd501);
        do_push('1);
        do_read(7'd0);
        do_read(7'd2);             // full-scale code drives the row below zero
        do_read(7'd3);             // past the written slots
        do_read(LAST_COL);
        do_noise();
        do_read(7'd1);
        do_clear();
        do_read(7'd0);
    endtask

    task automatic test_level_change();
        gap_pct = 24;
        do_clear();
        do_push(12'd300);
        load_regs(12'd200, ROW_STEP_RST, CFG_DATA_W'(BASELINE_RST));
        do_push(12'd250);          // 300 -> 250 is no crossing under the new level
        do_push(12'd150);
        do_push(12'd250);
        do_read(7'd0);
        do_read(7'd1);
    endtask

    task automatic test_trigger_window();
        gap_pct = 24;
        load_regs(TRIG_LEVEL_RST, ROW_STEP_RST, CFG_DATA_W'(BASELINE_RST));
        do_clear();
        repeat (VIEW_COLUMNS) do_push('0);
        do_push('1);               // crossing at the last display column
        do_read(7'd0);
        do_read(7'd1);
        do_read(LAST_COL);
        do_clear();
        repeat (VIEW_COLUMNS + 1) do_push('0);
        do_push('1);               // one slot too late to trigger
        do_read(7'd0);
        do_read(LAST_COL);
        while (int'(cap_count) < STORE_DEPTH) do_push(pick_code());
        do_read(pick_column());
        repeat (4) do_push(pick_code());   // dropped: store is full
        do_read(pick_column());
        do_read(LAST_COL);
    endtask

    task automatic test_register_extremes();
        gap_pct = 24;
        load_regs('0, 12'd1, {4'hF, 8'd0});
        run_captures(80);
        load_regs('1, '1, {4'h0, 8'd255});
        run_captures(80);
        load_regs('0, '0, {4'hA, 8'd255});     // zero divisor saturates the quotient
        run_captures(60);
        load_regs('1, 12'd1, {4'h5, 8'd255});
        run_captures(60);
        load_regs(SAMPLE_W'($urandom_range(4095)), '1, '0);
        run_captures(60);
    endtask

    task automatic test_random_traffic();
        int idle_plan [4];
        idle_plan = '{0, 84, 24, 0};
        foreach (idle_plan[p]) begin
            load_random_regs();
            gap_pct = idle_plan[p];
            run_captures(185);
        end
    endtask

    initial begin
        int drain;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_action    <= ACT_PUSH;
        i_sample    <= '0;
        i_column    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_TRIG_LEVEL;
        i_cfg_data  <= '0;
        err_count   = 0;
        items_sent  = 0;
        gap_pct     = 0;
        trig_level  = TRIG_LEVEL_RST;
        row_step    = ROW_STEP_RST;
        base_row    = BASELINE_RST;
        capture_restart();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_edge_cases();
        test_level_change();
        test_trigger_window();
        test_register_extremes();
        test_random_traffic();

        start <= 1'b0;
        drain = 0;
        while (readout_q.size() != 0 && drain < TAIL_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (readout_q.size() != 0)
            report_mismatch($sformatf("%0d reads never answered", readout_q.size()));
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
